// ===== rtl/core/tgc_pkg.sv =====
`timescale 1ns / 1ps

package tgc_pkg;

   localparam int COORD_BITS_DEF = 8;

   typedef enum logic [3:0] {
      G_LEAVE     = 4'd0,
      G_STAY      = 4'd1,
      G_PRESS     = 4'd2,
      G_LONGPRESS = 4'd3,
      G_HOLD      = 4'd4,
      G_SHORTREL  = 4'd5,
      G_LONGREL   = 4'd6,
      G_RELEASE   = 4'd7,
      G_UP        = 4'd8,
      G_DOWN      = 4'd9,
      G_LEFT      = 4'd10,
      G_RIGHT     = 4'd11
   } gesture_type;

   typedef enum logic [2:0] {
      CSR_PRESS_TOLERANCE       = 3'd0,
      CSR_LONG_PRESS_TICKS      = 3'd1,
      CSR_LONG_PRESS_WIDEN      = 3'd2,
      CSR_SLIDE_FIRST_THRESHOLD = 3'd3,
      CSR_SLIDE_NEXT_THRESHOLD  = 3'd4,
      CSR_SLIDE_WINDOW_TICKS    = 3'd5,
      CSR_SLIDE_MIN_STEPS       = 3'd6,
      CSR_SLIDE_FIRST_WINDOW    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [3:0] press_tolerance;
      logic [7:0] long_press_ticks;
      logic [3:0] long_press_widen;
      logic [6:0] slide_first_threshold;
      logic [6:0] slide_next_threshold;
      logic [7:0] slide_window_ticks;
      logic [1:0] slide_min_steps;
      logic [7:0] slide_first_window;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      press_tolerance:       4'd4,
      long_press_ticks:      8'd30,
      long_press_widen:      4'd6,
      slide_first_threshold: 7'd3,
      slide_next_threshold:  7'd2,
      slide_window_ticks:    8'd10,
      slide_min_steps:       2'd2,
      slide_first_window:    8'd40
   };

endpackage

// ===== rtl/core/tgc_csr.sv =====
`timescale 1ns / 1ps

module tgc_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   input  logic [2:0]       csr_index,
   input  logic [7:0]       csr_data,
   output tgc_pkg::cfg_type cfg
);
   import tgc_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_PRESS_TOLERANCE:       cfg_in.press_tolerance       = csr_data[3:0];
            CSR_LONG_PRESS_TICKS:      cfg_in.long_press_ticks      = csr_data;
            CSR_LONG_PRESS_WIDEN:      cfg_in.long_press_widen      = csr_data[3:0];
            CSR_SLIDE_FIRST_THRESHOLD: cfg_in.slide_first_threshold = csr_data[6:0];
            CSR_SLIDE_NEXT_THRESHOLD:  cfg_in.slide_next_threshold  = csr_data[6:0];
            CSR_SLIDE_WINDOW_TICKS:    cfg_in.slide_window_ticks    = csr_data;
            CSR_SLIDE_MIN_STEPS:       cfg_in.slide_min_steps       = csr_data[1:0];
            CSR_SLIDE_FIRST_WINDOW:    cfg_in.slide_first_window    = csr_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/tgc_dir.sv =====
`timescale 1ns / 1ps

module tgc_dir #(
   parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF
) (
   input  logic [COORD_BITS-1:0] ref_x,
   input  logic [COORD_BITS-1:0] ref_y,
   input  logic [COORD_BITS-1:0] cur_x,
   input  logic [COORD_BITS-1:0] cur_y,
   input  logic [6:0]            threshold,
   output tgc_pkg::gesture_type  dir
);
   import tgc_pkg::*;

   localparam int AW = COORD_BITS + 2;
   localparam int TW = (COORD_BITS > 7) ? COORD_BITS : 7;

   logic signed [COORD_BITS:0] dx, dy;
   logic [COORD_BITS:0]        ndx, ndy;
   logic [COORD_BITS-1:0]      ax, ay;
   logic [AW-1:0]              ax2, ay2, ax3, ay3;
   logic [TW-1:0]              axw, ayw, thw;
   logic                       vdom, hdom;

   assign dx  = $signed({1'b0, cur_x}) - $signed({1'b0, ref_x});
   assign dy  = $signed({1'b0, cur_y}) - $signed({1'b0, ref_y});
   assign ndx = -dx;
   assign ndy = -dy;
   assign ax  = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
   assign ay  = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

   // 3:2 dominance: 2*|a| >= 3*|b|
   assign ax2 = {1'b0, ax, 1'b0};
   assign ay2 = {1'b0, ay, 1'b0};
   assign ax3 = ax2 + AW'(ax);
   assign ay3 = ay2 + AW'(ay);
   assign vdom = ay2 >= ax3;
   assign hdom = ax2 >= ay3;

   assign axw = TW'(ax);
   assign ayw = TW'(ay);
   assign thw = TW'(threshold);

   always_comb begin
      dir = G_LEAVE;
      if (dy[COORD_BITS] && ayw > thw && vdom) begin
         dir = G_UP;
      end else if (!dy[COORD_BITS] && ayw > thw && vdom) begin
         dir = G_DOWN;
      end else if (dx[COORD_BITS] && axw > thw && hdom) begin
         dir = G_LEFT;
      end else if (!dx[COORD_BITS] && axw > thw && hdom) begin
         dir = G_RIGHT;
      end
   end

endmodule

// ===== rtl/core/tgc_core.sv =====
`timescale 1ns / 1ps

module tgc_core #(
   parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic                   touched,
   input  logic [COORD_BITS-1:0]  x_pos,
   input  logic [COORD_BITS-1:0]  y_pos,
   input  logic                   forced_leave,
   input  tgc_pkg::cfg_type       cfg,
   output tgc_pkg::gesture_type   gesture,
   output logic signed [COORD_BITS:0] point_x,
   output logic signed [COORD_BITS:0] point_y,
   output logic [COORD_BITS-1:0]  first_x,
   output logic [COORD_BITS-1:0]  first_y,
   output logic [COORD_BITS-1:0]  last_x,
   output logic [COORD_BITS-1:0]  last_y
);
   import tgc_pkg::*;

   localparam int BW = COORD_BITS + 2;

   logic pressed_ff, pressed_in;
   logic await_ff, await_in;
   logic long_on_ff, long_on_in;
   logic slide_on_ff, slide_on_in;
   logic fired_ff, fired_in;
   logic [7:0] dwell_ff, dwell_in, dwell_sat;
   logic signed [BW-1:0] box_l_ff, box_l_in, box_t_ff, box_t_in;
   logic signed [BW-1:0] box_r_ff, box_r_in, box_b_ff, box_b_in;
   logic [COORD_BITS-1:0] ref_x_ff, ref_x_in, ref_y_ff, ref_y_in;
   gesture_type lock_ff, lock_in, pending_ff, pending_in, dir, g;
   logic [1:0] step_ff, step_in, step_sat;
   logic [7:0] timer_ff, timer_in, timer_mid;
   logic [6:0] thr_ff, thr_in;
   logic signed [COORD_BITS:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic [COORD_BITS-1:0] last_x_ff, last_x_in, last_y_ff, last_y_in;

   logic signed [BW-1:0] xs, ys, tol_s, wid_s;
   logic in_box;

   tgc_dir #(.COORD_BITS(COORD_BITS)) u_dir (
      .ref_x     (ref_x_ff),
      .ref_y     (ref_y_ff),
      .cur_x     (x_pos),
      .cur_y     (y_pos),
      .threshold (thr_ff),
      .dir       (dir)
   );

   assign xs    = signed'({2'b00, x_pos});
   assign ys    = signed'({2'b00, y_pos});
   assign tol_s = signed'(BW'(cfg.press_tolerance));
   assign wid_s = signed'(BW'(cfg.long_press_widen));
   assign in_box = (xs > box_l_ff) && (xs < box_r_ff) && (ys > box_t_ff) && (ys < box_b_ff);
   assign dwell_sat = (dwell_ff != 8'hFF) ? dwell_ff + 8'd1 : dwell_ff;
   assign step_sat  = (step_ff < cfg.slide_min_steps) ? step_ff + 2'd1 : step_ff;

   always_comb begin
      pressed_in = pressed_ff;
      await_in   = await_ff;
      long_on_in = long_on_ff;
      slide_on_in = slide_on_ff;
      fired_in   = fired_ff;
      dwell_in   = dwell_ff;
      box_l_in   = box_l_ff;
      box_t_in   = box_t_ff;
      box_r_in   = box_r_ff;
      box_b_in   = box_b_ff;
      ref_x_in   = ref_x_ff;
      ref_y_in   = ref_y_ff;
      lock_in    = lock_ff;
      step_in    = step_ff;
      timer_in   = timer_ff;
      timer_mid  = timer_ff;
      thr_in     = thr_ff;
      pending_in = pending_ff;
      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      last_x_in  = last_x_ff;
      last_y_in  = last_y_ff;
      g          = G_LEAVE;

      if (forced_leave) begin
         pressed_in  = 1'b1;
         long_on_in  = 1'b0;
         slide_on_in = 1'b0;
         await_in    = 1'b1;
         pending_in  = G_LEAVE;
         g           = G_LEAVE;
      end else if (touched) begin
         await_in = 1'b1;
         cur_x_in = signed'({1'b0, x_pos});
         cur_y_in = signed'({1'b0, y_pos});
         g        = G_STAY;
         if (!pressed_ff) begin
            pressed_in = 1'b1;
            g          = G_PRESS;
            pending_in = G_SHORTREL;
            box_l_in   = xs - tol_s;
            box_t_in   = ys - tol_s;
            box_r_in   = xs + tol_s;
            box_b_in   = ys + tol_s;
            ref_x_in   = x_pos;
            ref_y_in   = y_pos;
            first_x_in = x_pos;
            first_y_in = y_pos;
         end else begin
            if (long_on_ff) begin
               if (in_box) begin
                  if (!fired_ff) begin
                     dwell_in = dwell_sat;
                     if (dwell_sat >= cfg.long_press_ticks) begin
                        slide_on_in = 1'b0;
                        fired_in    = 1'b1;
                        box_l_in    = box_l_ff - wid_s;
                        box_t_in    = box_t_ff - wid_s;
                        box_r_in    = box_r_ff + wid_s;
                        box_b_in    = box_b_ff + wid_s;
                        g           = G_LONGPRESS;
                        pending_in  = G_LONGREL;
                     end
                  end else begin
                     g = G_HOLD;
                  end
               end else begin
                  long_on_in = 1'b0;
                  pending_in = G_RELEASE;
               end
            end
            // swipe tracking sees the slide flag after the long-press step
            if (slide_on_in) begin
               if (lock_ff != G_LEAVE) begin
                  if (dir == lock_ff) begin
                     timer_mid = cfg.slide_window_ticks;
                     step_in   = step_sat;
                     ref_x_in  = x_pos;
                     ref_y_in  = y_pos;
                  end else if (dir != G_LEAVE) begin
                     slide_on_in = 1'b0;
                     step_in     = 2'd0;
                  end
               end else if (dir != G_LEAVE) begin
                  lock_in   = dir;
                  thr_in    = cfg.slide_next_threshold;
                  step_in   = step_sat;
                  timer_mid = cfg.slide_window_ticks;
                  ref_x_in  = x_pos;
                  ref_y_in  = y_pos;
               end
               if (timer_mid != 8'd0) begin
                  timer_in = timer_mid - 8'd1;
               end else begin
                  timer_in    = timer_mid;
                  slide_on_in = 1'b0;
                  lock_in     = G_LEAVE;
               end
            end
         end
      end else begin
         g = pending_ff;
         if (await_ff) begin
            await_in = 1'b0;
            if (slide_on_ff && step_ff >= cfg.slide_min_steps) begin
               last_x_in = cur_x_ff[COORD_BITS-1:0];
               last_y_in = cur_y_ff[COORD_BITS-1:0];
               if (lock_ff != G_LEAVE) begin
                  g = lock_ff;
               end
            end
            pressed_in  = 1'b0;
            fired_in    = 1'b0;
            dwell_in    = 8'd0;
            long_on_in  = 1'b1;
            slide_on_in = 1'b1;
            lock_in     = G_LEAVE;
            step_in     = 2'd0;
            timer_in    = cfg.slide_first_window;
            thr_in      = cfg.slide_first_threshold;
            cur_x_in    = '1;
            cur_y_in    = '1;
         end
         pending_in = G_LEAVE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff  <= 1'b0;
         await_ff    <= 1'b1;
         long_on_ff  <= 1'b1;
         slide_on_ff <= 1'b1;
         fired_ff    <= 1'b0;
         dwell_ff    <= 8'd0;
         box_l_ff    <= '0;
         box_t_ff    <= '0;
         box_r_ff    <= '0;
         box_b_ff    <= '0;
         ref_x_ff    <= '0;
         ref_y_ff    <= '0;
         lock_ff     <= G_LEAVE;
         step_ff     <= 2'd0;
         timer_ff    <= CFG_RESET.slide_first_window;
         thr_ff      <= CFG_RESET.slide_first_threshold;
         pending_ff  <= G_LEAVE;
         cur_x_ff    <= '1;
         cur_y_ff    <= '1;
         first_x_ff  <= '0;
         first_y_ff  <= '0;
         last_x_ff   <= '0;
         last_y_ff   <= '0;
      end else if (fire) begin
         pressed_ff  <= pressed_in;
         await_ff    <= await_in;
         long_on_ff  <= long_on_in;
         slide_on_ff <= slide_on_in;
         fired_ff    <= fired_in;
         dwell_ff    <= dwell_in;
         box_l_ff    <= box_l_in;
         box_t_ff    <= box_t_in;
         box_r_ff    <= box_r_in;
         box_b_ff    <= box_b_in;
         ref_x_ff    <= ref_x_in;
         ref_y_ff    <= ref_y_in;
         lock_ff     <= lock_in;
         step_ff     <= step_in;
         timer_ff    <= timer_in;
         thr_ff      <= thr_in;
         pending_ff  <= pending_in;
         cur_x_ff    <= cur_x_in;
         cur_y_ff    <= cur_y_in;
         first_x_ff  <= first_x_in;
         first_y_ff  <= first_y_in;
         last_x_ff   <= last_x_in;
         last_y_ff   <= last_y_in;
      end
   end

   assign gesture = g;
   assign point_x = cur_x_in;
   assign point_y = cur_y_in;
   assign first_x = first_x_in;
   assign first_y = first_y_in;
   assign last_x  = last_x_in;
   assign last_y  = last_y_in;

endmodule

// ===== rtl/core/touch_gesture_classifier.sv =====
`timescale 1ns / 1ps

// Touch gesture classifier. One touch-panel scan sample enters per item on the
// req_ channel (touched, x_pos, y_pos, forced_leave); exactly one item leaves on
// the rsp_ channel: gesture code, current point (-1 after a release), press
// start point and end point of the last reported swipe.
// Samples are captured in an input register; the classifier state and the
// result register update together when the result register is free, and the
// result is offered from it. One sample per cycle is sustained while rsp_ready
// is high: the state update is a single pass of compare/add logic per sample.
// When rsp_ready is low the result register holds; the input register still
// takes one more sample, after which req_ready drops until the result drains.
// Configuration writes on csr_ are always ready and are registered before they
// take effect; issue them only while no sample is in flight.
// Synchronous reset loads the register defaults and the released-panel state
// (point -1, no press pending, all checks armed) and empties both registers.
module touch_gesture_classifier #(
   parameter int COORD_BITS = tgc_pkg::COORD_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_touched,
   input  logic [COORD_BITS-1:0]  req_x_pos,
   input  logic [COORD_BITS-1:0]  req_y_pos,
   input  logic                   req_forced_leave,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [3:0]             rsp_gesture,
   output logic signed [COORD_BITS:0] rsp_point_x,
   output logic signed [COORD_BITS:0] rsp_point_y,
   output logic [COORD_BITS-1:0]  rsp_first_x,
   output logic [COORD_BITS-1:0]  rsp_first_y,
   output logic [COORD_BITS-1:0]  rsp_last_x,
   output logic [COORD_BITS-1:0]  rsp_last_y,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [7:0]             csr_data
);
   import tgc_pkg::*;

   cfg_type cfg;

   logic in_valid_ff, in_valid_in;
   logic touched_ff, forced_ff;
   logic [COORD_BITS-1:0] x_ff, y_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free, fire, req_take;

   gesture_type g;
   logic signed [COORD_BITS:0] px, py;
   logic [COORD_BITS-1:0] fx, fy, lx, ly;

   logic [3:0] gesture_ff;
   logic signed [COORD_BITS:0] point_x_ff, point_y_ff;
   logic [COORD_BITS-1:0] first_x_ff, first_y_ff, last_x_ff, last_y_ff;

   tgc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   tgc_core #(.COORD_BITS(COORD_BITS)) u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .touched      (touched_ff),
      .x_pos        (x_ff),
      .y_pos        (y_ff),
      .forced_leave (forced_ff),
      .cfg          (cfg),
      .gesture      (g),
      .point_x      (px),
      .point_y      (py),
      .first_x      (fx),
      .first_y      (fy),
      .last_x       (lx),
      .last_y       (ly)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         touched_ff <= req_touched;
         x_ff       <= req_x_pos;
         y_ff       <= req_y_pos;
         forced_ff  <= req_forced_leave;
      end
      if (fire) begin
         gesture_ff <= g;
         point_x_ff <= px;
         point_y_ff <= py;
         first_x_ff <= fx;
         first_y_ff <= fy;
         last_x_ff  <= lx;
         last_y_ff  <= ly;
      end
   end

   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_gesture = gesture_ff;
   assign rsp_point_x = point_x_ff;
   assign rsp_point_y = point_y_ff;
   assign rsp_first_x = first_x_ff;
   assign rsp_first_y = first_y_ff;
   assign rsp_last_x  = last_x_ff;
   assign rsp_last_y  = last_y_ff;

endmodule

// ===== dv/touch_gesture_classifier_checker.sv =====
`timescale 1ns / 1ps

module touch_gesture_classifier_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              req_touched,
   input  logic [7:0]        req_x_pos,
   input  logic [7:0]        req_y_pos,
   input  logic              req_forced_leave,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [3:0]        rsp_gesture,
   input  logic signed [8:0] rsp_point_x,
   input  logic signed [8:0] rsp_point_y,
   input  logic [7:0]        rsp_first_x,
   input  logic [7:0]        rsp_first_y,
   input  logic [7:0]        rsp_last_x,
   input  logic [7:0]        rsp_last_y,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [7:0]        csr_data,
   output int                error_count,
   output int                outstanding
);
   import tgc_pkg::*;

   localparam gesture_type NO_DIRECTION = G_LEAVE;

   typedef struct packed {
      gesture_type       gesture;
      logic signed [8:0] point_x;
      logic signed [8:0] point_y;
      logic [7:0]        first_x;
      logic [7:0]        first_y;
      logic [7:0]        last_x;
      logic [7:0]        last_y;
   } gesture_result_type;

   cfg_type cfg;

   logic              pressed_seen, await_release, long_check_on, slide_check_on, long_fired;
   logic [7:0]        dwell_count;
   logic signed [10:0] box_l, box_t, box_r, box_b;
   logic signed [9:0] ref_x, ref_y;
   gesture_type       lock_dir;
   logic [1:0]        step_count;
   logic [7:0]        window_timer;
   logic [6:0]        active_thr;
   gesture_type       pending_code;
   logic signed [9:0] cur_x, cur_y;
   logic [7:0]        first_x, first_y, last_x, last_y;

   gesture_result_type expected_results[$];

   function automatic gesture_type swipe_direction(int sx, int sy, int cx, int cy, int thr);
      int dx, dy, ax, ay;
      bit vdom, hdom;
      dx = cx - sx;
      dy = cy - sy;
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      // 3:2 dominance, ties count for both axes
      vdom = (ay * 2 >= ax * 3);
      hdom = (ax * 2 >= ay * 3);
      if (dy < -thr && vdom) return G_UP;
      if (dy > thr && vdom) return G_DOWN;
      if (dx < -thr && hdom) return G_LEFT;
      if (dx > thr && hdom) return G_RIGHT;
      return NO_DIRECTION;
   endfunction

   function void restart_tracking();
      pressed_seen   = 1'b0;
      long_fired     = 1'b0;
      dwell_count    = '0;
      long_check_on  = 1'b1;
      slide_check_on = 1'b1;
      lock_dir       = NO_DIRECTION;
      step_count     = '0;
      window_timer   = cfg.slide_first_window;
      active_thr     = cfg.slide_first_threshold;
      cur_x          = '1;
      cur_y          = '1;
   endfunction

   function void track_swipe();
      gesture_type dir;
      dir = swipe_direction(ref_x, ref_y, cur_x, cur_y, active_thr);
      if (lock_dir != NO_DIRECTION) begin
         if (dir == lock_dir) begin
            window_timer = cfg.slide_window_ticks;
            if (step_count < cfg.slide_min_steps) step_count++;
            ref_x = cur_x;
            ref_y = cur_y;
         end else if (dir != NO_DIRECTION) begin
            slide_check_on = 1'b0;
            step_count = '0;
         end
      end else if (dir != NO_DIRECTION) begin
         lock_dir = dir;
         active_thr = cfg.slide_next_threshold;
         if (step_count < cfg.slide_min_steps) step_count++;
         window_timer = cfg.slide_window_ticks;
         ref_x = cur_x;
         ref_y = cur_y;
      end
      if (window_timer != 0) begin
         window_timer--;
      end else begin
         slide_check_on = 1'b0;
         lock_dir = NO_DIRECTION;
      end
   endfunction

   function gesture_result_type classify(logic touched, logic [7:0] x, logic [7:0] y,
                                         logic forced);
      gesture_result_type r;
      gesture_type g;
      int xi, yi, tol, grow;
      xi = x;
      yi = y;
      if (forced) begin
         pressed_seen   = 1'b1;
         long_check_on  = 1'b0;
         slide_check_on = 1'b0;
         await_release  = 1'b1;
         pending_code   = G_LEAVE;
         g = G_LEAVE;
      end else if (touched) begin
         await_release = 1'b1;
         cur_x = 10'(xi);
         cur_y = 10'(yi);
         g = G_STAY;
         if (!pressed_seen) begin
            tol = cfg.press_tolerance;
            pressed_seen = 1'b1;
            g = G_PRESS;
            pending_code = G_SHORTREL;
            box_l = 11'(xi - tol);
            box_t = 11'(yi - tol);
            box_r = 11'(xi + tol);
            box_b = 11'(yi + tol);
            ref_x = 10'(xi);
            ref_y = 10'(yi);
            first_x = x;
            first_y = y;
         end else begin
            if (long_check_on) begin
               // box test is strict on all four sides
               if (xi > box_l && xi < box_r && yi > box_t && yi < box_b) begin
                  if (!long_fired) begin
                     if (dwell_count < 8'd255) dwell_count++;
                     if (dwell_count >= cfg.long_press_ticks) begin
                        grow = cfg.long_press_widen;
                        slide_check_on = 1'b0;
                        long_fired = 1'b1;
                        box_l = 11'(box_l - grow);
                        box_t = 11'(box_t - grow);
                        box_r = 11'(box_r + grow);
                        box_b = 11'(box_b + grow);
                        g = G_LONGPRESS;
                        pending_code = G_LONGREL;
                     end
                  end else begin
                     g = G_HOLD;
                  end
               end else begin
                  long_check_on = 1'b0;
                  pending_code = G_RELEASE;
               end
            end
            if (slide_check_on) track_swipe();
         end
      end else begin
         g = pending_code;
         // only the first untouched sample after a touch, a forced leave or reset does release work
         if (await_release) begin
            await_release = 1'b0;
            if (slide_check_on && step_count >= cfg.slide_min_steps) begin
               last_x = cur_x[7:0];
               last_y = cur_y[7:0];
               if (lock_dir != NO_DIRECTION) g = lock_dir;
            end
            restart_tracking();
         end
         pending_code = G_LEAVE;
      end
      r.gesture = g;
      r.point_x = cur_x[8:0];
      r.point_y = cur_y[8:0];
      r.first_x = first_x;
      r.first_y = first_y;
      r.last_x  = last_x;
      r.last_y  = last_y;
      return r;
   endfunction

   task automatic check_field(string name, logic [8:0] want, logic [8:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      gesture_result_type want;
      if (reset) begin
         cfg = CFG_RESET;
         restart_tracking();
         await_release = 1'b1;
         box_l = '0;
         box_t = '0;
         box_r = '0;
         box_b = '0;
         ref_x = '0;
         ref_y = '0;
         pending_code = G_LEAVE;
         first_x = '0;
         first_y = '0;
         last_x = '0;
         last_y = '0;
         expected_results.delete();
         outstanding = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_PRESS_TOLERANCE:       cfg.press_tolerance       = csr_data[3:0];
               CSR_LONG_PRESS_TICKS:      cfg.long_press_ticks      = csr_data;
               CSR_LONG_PRESS_WIDEN:      cfg.long_press_widen      = csr_data[3:0];
               CSR_SLIDE_FIRST_THRESHOLD: cfg.slide_first_threshold = csr_data[6:0];
               CSR_SLIDE_NEXT_THRESHOLD:  cfg.slide_next_threshold  = csr_data[6:0];
               CSR_SLIDE_WINDOW_TICKS:    cfg.slide_window_ticks    = csr_data;
               CSR_SLIDE_MIN_STEPS:       cfg.slide_min_steps       = csr_data[1:0];
               CSR_SLIDE_FIRST_WINDOW:    cfg.slide_first_window    = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t ns: result item with none expected, gesture %0d",
                        $time, rsp_gesture);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("gesture", want.gesture, rsp_gesture);
               check_field("point_x", want.point_x, rsp_point_x);
               check_field("point_y", want.point_y, rsp_point_y);
               check_field("first_x", want.first_x, rsp_first_x);
               check_field("first_y", want.first_y, rsp_first_y);
               check_field("last_x", want.last_x, rsp_last_x);
               check_field("last_y", want.last_y, rsp_last_y);
            end
         end
         if (req_valid && req_ready) begin
            expected_results.push_back(classify(req_touched, req_x_pos, req_y_pos,
                                                req_forced_leave));
         end
         outstanding = expected_results.size();
      end
   end

endmodule

// ===== dv/touch_gesture_classifier_test.sv =====
`timescale 1ns / 1ps

module touch_gesture_classifier_test;
   import tgc_pkg::*;

   localparam int CYCLE_LIMIT = 500000;

   logic              clock, reset;
   logic              req_valid, req_ready, req_touched, req_forced_leave;
   logic [7:0]        req_x_pos, req_y_pos;
   logic              rsp_valid, rsp_ready;
   logic [3:0]        rsp_gesture;
   logic signed [8:0] rsp_point_x, rsp_point_y;
   logic [7:0]        rsp_first_x, rsp_first_y, rsp_last_x, rsp_last_y;
   logic              csr_valid, csr_ready;
   logic [2:0]        csr_index;
   logic [7:0]        csr_data;
   int                error_count, outstanding;

   cfg_type live_cfg;
   int      samples_sent;
   int      send_calm;
   bit      quiet;
   bit      long_hold_req;

   touch_gesture_classifier dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_touched(req_touched),
      .req_x_pos(req_x_pos),
      .req_y_pos(req_y_pos),
      .req_forced_leave(req_forced_leave),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_gesture(rsp_gesture),
      .rsp_point_x(rsp_point_x),
      .rsp_point_y(rsp_point_y),
      .rsp_first_x(rsp_first_x),
      .rsp_first_y(rsp_first_y),
      .rsp_last_x(rsp_last_x),
      .rsp_last_y(rsp_last_y),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   touch_gesture_classifier_checker gesture_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_touched(req_touched),
      .req_x_pos(req_x_pos),
      .req_y_pos(req_y_pos),
      .req_forced_leave(req_forced_leave),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_gesture(rsp_gesture),
      .rsp_point_x(rsp_point_x),
      .rsp_point_y(rsp_point_y),
      .rsp_first_x(rsp_first_x),
      .rsp_first_y(rsp_first_y),
      .rsp_last_x(rsp_last_x),
      .rsp_last_y(rsp_last_y),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .error_count(error_count),
      .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("touch_gesture_classifier_test: done, errors");
      $finish;
   end

   // result side: random stalls, calm stretches, and one long hold-off on request
   initial begin
      int stall_left, calm_left;
      stall_left = 0;
      calm_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall_left = 60;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (calm_left > 0) begin
               calm_left--;
            end else if (!quiet && $urandom_range(0, 40) == 0) begin
               calm_left = $urandom_range(20, 80);
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
               stall_left = $urandom_range(1, 9);
            end
         end
      end
   end

   function automatic int jitter(int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   task automatic send_sample(bit touched, int x, int y, bit forced);
      int gap;
      if (send_calm > 0) begin
         send_calm--;
      end else if ($urandom_range(0, 30) == 0) begin
         send_calm = $urandom_range(10, 60);
      end
      if (!quiet && send_calm == 0 && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_touched      <= touched;
      req_x_pos        <= (x < 0) ? 8'd0 : (x > 255) ? 8'd255 : 8'(x);
      req_y_pos        <= (y < 0) ? 8'd0 : (y > 255) ? 8'd255 : 8'(y);
      req_forced_leave <= forced;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      samples_sent++;
   endtask

   // stop offering items and wait until every result has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic csr_put(csr_index_type idx, logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // unused upper data bits get random values
   task automatic program_cfg(cfg_type c);
      csr_put(CSR_PRESS_TOLERANCE, {4'($urandom), c.press_tolerance});
      csr_put(CSR_LONG_PRESS_TICKS, c.long_press_ticks);
      csr_put(CSR_LONG_PRESS_WIDEN, {4'($urandom), c.long_press_widen});
      csr_put(CSR_SLIDE_FIRST_THRESHOLD, {1'($urandom), c.slide_first_threshold});
      csr_put(CSR_SLIDE_NEXT_THRESHOLD, {1'($urandom), c.slide_next_threshold});
      csr_put(CSR_SLIDE_WINDOW_TICKS, c.slide_window_ticks);
      csr_put(CSR_SLIDE_MIN_STEPS, {6'($urandom), c.slide_min_steps});
      csr_put(CSR_SLIDE_FIRST_WINDOW, c.slide_first_window);
      @(negedge clock);
      csr_valid <= 1'b0;
      live_cfg = c;
   endtask

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.press_tolerance = 4'($urandom_range(0, 15));
      c.long_press_ticks = ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 24));
      c.long_press_widen = 4'($urandom_range(0, 15));
      c.slide_first_threshold = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                            : 7'($urandom_range(0, 8));
      c.slide_next_threshold = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                           : 7'($urandom_range(0, 8));
      c.slide_window_ticks = 8'($urandom_range(0, 24));
      c.slide_min_steps = 2'($urandom_range(0, 3));
      c.slide_first_window = 8'($urandom_range(0, 60));
      return c;
   endfunction

   task automatic lift_finger();
      repeat ($urandom_range(1, 2))
         send_sample(1'b0, $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
   endtask

   task automatic run_stroke();
      int kind, px, py, span, dir, stride, steps;
      kind = $urandom_range(0, 19);
      px = $urandom_range(0, 255);
      py = $urandom_range(0, 255);
      if (kind < 2) begin
         repeat ($urandom_range(1, 6))
            send_sample(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 5) == 0);
      end else if (kind < 6) begin
         // tap or wander around the box edge
         send_sample(1'b1, px, py, 1'b0);
         span = live_cfg.press_tolerance + 2;
         repeat ($urandom_range(0, 8))
            send_sample(1'b1, px + jitter(span), py + jitter(span), 1'b0);
         lift_finger();
      end else if (kind < 11) begin
         // dwell strictly inside the box, then hold inside the widened box
         send_sample(1'b1, px, py, 1'b0);
         span = (live_cfg.press_tolerance > 1) ? live_cfg.press_tolerance - 1 : 0;
         repeat (live_cfg.long_press_ticks + $urandom_range(0, 6))
            send_sample(1'b1, px + jitter(span), py + jitter(span), 1'b0);
         span = span + live_cfg.long_press_widen;
         repeat ($urandom_range(0, 6))
            send_sample(1'b1, px + jitter(span), py + jitter(span), 1'b0);
         if ($urandom_range(0, 2) == 0)
            send_sample(1'b1, px + jitter(40), py + jitter(40), 1'b0);
         lift_finger();
      end else if (kind < 18) begin
         send_sample(1'b1, px, py, 1'b0);
         dir = $urandom_range(0, 3);
         stride = live_cfg.slide_first_threshold + $urandom_range(1, 5);
         steps = $urandom_range(1, 4);
         repeat (steps) begin
            repeat ($urandom_range(0, 2)) send_sample(1'b1, px, py, 1'b0);
            // sometimes sit still for the window length or a little more (20 samples when the window is over 40)
            if ($urandom_range(0, 5) == 0)
               repeat ((live_cfg.slide_window_ticks > 40) ? 20 :
                       live_cfg.slide_window_ticks + $urandom_range(0, 3))
                  send_sample(1'b1, px, py, 1'b0);
            if ($urandom_range(0, 7) == 0) dir = $urandom_range(0, 3);
            case (dir)
               0: begin py -= stride; px += jitter(stride / 3); end
               1: begin py += stride; px += jitter(stride / 3); end
               2: begin px -= stride; py += jitter(stride / 3); end
               default: begin px += stride; py += jitter(stride / 3); end
            endcase
            send_sample(1'b1, px, py, 1'b0);
            stride = live_cfg.slide_next_threshold + $urandom_range(1, 5);
         end
         lift_finger();
      end else if (kind == 18) begin
         send_sample(1'b1, px, py, 1'b0);
         repeat ($urandom_range(0, 3)) send_sample(1'b1, px + jitter(6), py + jitter(6), 1'b0);
         send_sample(1'($urandom_range(0, 1)), $urandom_range(0, 255),
                     $urandom_range(0, 255), 1'b1);
         repeat ($urandom_range(0, 3)) send_sample(1'b1, px + jitter(6), py + jitter(6), 1'b0);
         lift_finger();
      end else begin
         lift_finger();
      end
   endtask

   initial begin
      cfg_type setting;
      reset = 1'b1;
      req_valid = 1'b0;
      req_touched = 1'b0;
      req_x_pos = '0;
      req_y_pos = '0;
      req_forced_leave = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      quiet = 1'b0;
      long_hold_req = 1'b0;
      send_calm = 0;
      samples_sent = 0;
      live_cfg = CFG_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // release before any touch, tap at the origin, double release
      send_sample(1'b0, 0, 0, 1'b0);
      send_sample(1'b1, 0, 0, 1'b0);
      send_sample(1'b1, 1, 1, 1'b0);
      send_sample(1'b0, 255, 255, 1'b0);
      send_sample(1'b0, 255, 255, 1'b0);
      // press at the far corner, leave the box, swipe left
      send_sample(1'b1, 255, 255, 1'b0);
      send_sample(1'b1, 200, 255, 1'b0);
      send_sample(1'b1, 150, 255, 1'b0);
      send_sample(1'b0, 0, 0, 1'b0);
      // down step, then a right step breaks the swipe
      send_sample(1'b1, 100, 10, 1'b0);
      send_sample(1'b1, 100, 20, 1'b0);
      send_sample(1'b1, 110, 20, 1'b0);
      send_sample(1'b0, 100, 20, 1'b0);
      // forced leave during a touch
      send_sample(1'b1, 50, 50, 1'b0);
      send_sample(1'b1, 60, 60, 1'b1);
      send_sample(1'b1, 50, 50, 1'b0);
      send_sample(1'b0, 50, 50, 1'b0);
      // swipe up
      send_sample(1'b1, 128, 200, 1'b0);
      send_sample(1'b1, 128, 150, 1'b0);
      send_sample(1'b1, 128, 100, 1'b0);
      send_sample(1'b0, 0, 255, 1'b0);
      // swipe right at the exact 3:2 dominance boundary
      send_sample(1'b1, 20, 20, 1'b0);
      send_sample(1'b1, 26, 24, 1'b0);
      send_sample(1'b1, 32, 28, 1'b0);
      send_sample(1'b0, 0, 0, 1'b0);

      while (samples_sent < 400) run_stroke();

      drain();
      program_cfg('0);
      while (samples_sent < 600) run_stroke();

      drain();
      program_cfg('1);
      while (samples_sent < 950) run_stroke();

      drain();
      setting = '{press_tolerance: 4'd6, long_press_ticks: 8'd3, long_press_widen: 4'd15,
                  slide_first_threshold: 7'd0, slide_next_threshold: 7'd0,
                  slide_window_ticks: 8'd255, slide_min_steps: 2'd3,
                  slide_first_window: 8'd255};
      program_cfg(setting);
      long_hold_req = 1'b1;
      while (samples_sent < 1350) run_stroke();

      drain();
      program_cfg(random_cfg());
      while (samples_sent < 1650) run_stroke();

      drain();
      quiet = 1'b1;
      program_cfg(random_cfg());
      while (samples_sent < 1925) run_stroke();

      drain();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("touch_gesture_classifier_test: done, clean");
      end else begin
         $display("touch_gesture_classifier_test: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/tgc_pkg.sv
rtl/core/tgc_csr.sv
rtl/core/tgc_dir.sv
rtl/core/tgc_core.sv
rtl/core/touch_gesture_classifier.sv
dv/touch_gesture_classifier_checker.sv
dv/touch_gesture_classifier_test.sv
